// ----- src/cale_pkg.sv -----
`default_nettype none
package cale_pkg;

  // Stored word
  typedef logic [31:0] word_t;

  // Command codes
  typedef enum logic [3:0] {
    CMD_CLEAR  = 4'd0,
    CMD_INSERT = 4'd1,
    CMD_APPEND = 4'd2,
    CMD_ERASE  = 4'd3,
    CMD_START  = 4'd4,
    CMD_END    = 4'd5,
    CMD_PREV   = 4'd6,
    CMD_NEXT   = 4'd7,
    CMD_MOVE   = 4'd8,
    CMD_READ   = 4'd9
  } cmd_t;

  // Per-cell update control
  typedef struct packed {
    logic up;    // take the word of the left neighbour
    logic dn;    // take the word of the right neighbour
    logic load;  // take the new word
    logic sel;   // cell sits under the cursor
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- src/cursor_array_list_engine_unit.sv -----
`default_nettype none
// Ordered list of signed 32-bit words in a row of DEPTH cells, with a cursor.
// Insert and erase shift the cells from the cursor on; append loads the cell
// after the last entry. A command passes an accept and an execute step; erase
// and read pass a gather step between, as the word under the cursor is first
// gathered through a registered OR tree of 32-cell groups. One command is in
// work at a time; a result waiting on out_ready holds it in its execute step.
module cursor_array_list_engine_unit
  import cale_pkg::*;
#(
  parameter int DEPTH = 512
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_cmd,
  input  wire logic signed [31:0] in_item_value,
  input  wire logic [9:0]         in_target_pos,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_data_out,
  output logic                    out_ok,
  output logic [9:0]              out_position,
  output logic [9:0]              out_length
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int TW    = (CW > 10) ? CW : 10;
  localparam int GROUP = 32;
  localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [TW-1:0] DEPTH_T = TW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_EXEC   = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [3:0]    cmd_r;
  word_t         val_r;
  logic [9:0]    tgt_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;

  logic          out_valid_r;
  word_t         out_data_r, res_data;
  logic          out_ok_r, res_ok;
  logic [9:0]    out_pos_r, out_len_r;
  logic [CW-1:0] res_pos;

  logic          in_fire, fire;
  logic          full, on_elem;
  logic [CW-1:0] at_w, ld_at;
  logic          do_ins, do_load, do_ers;
  logic [TW-1:0] tgt_ext, pos_ext, len_ext;
  word_t         gather_word;

  word_t     [DEPTH-1:0]      cell_word;
  word_t     [NGRP*GROUP-1:0] cell_tap;
  cell_ctl_t [DEPTH-1:0]      cell_ctl;
  word_t     [NGRP-1:0]       grp_word;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // command decode against the current list
  assign full    = (count_r == DEPTH_C);
  assign on_elem = (cursor_r < count_r);
  assign at_w    = on_elem ? cursor_r : count_r;
  assign ld_at   = (cmd_r == CMD_INSERT) ? at_w : count_r;
  assign do_ins  = fire && (cmd_r == CMD_INSERT) && !full;
  assign do_load = fire && ((cmd_r == CMD_INSERT) || (cmd_r == CMD_APPEND)) && !full;
  assign do_ers  = fire && (cmd_r == CMD_ERASE) && on_elem;
  assign tgt_ext = TW'(tgt_r);

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    word_t left_w, right_w;

    assign cell_ctl[i].up   = do_ins && (IDX > at_w);
    assign cell_ctl[i].dn   = do_ers && (IDX >= cursor_r);
    assign cell_ctl[i].load = do_load && (IDX == ld_at);
    assign cell_ctl[i].sel  = (IDX == cursor_r);

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    cale_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .left_word  (left_w),
      .right_word (right_w),
      .load_word  (val_r),
      .word       (cell_word[i]),
      .tap        (cell_tap[i])
    );
  end

  // pad the last group
  for (genvar p = DEPTH; p < NGRP * GROUP; p++) begin : g_pad
    assign cell_tap[p] = '0;
  end

  // first level of the cursor read tree
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    cale_group #(.GROUP(GROUP)) u_grp (
      .clk   (clk),
      .taps  (cell_tap[g*GROUP +: GROUP]),
      .grp_r (grp_word[g])
    );
  end

  // second level, used in the execute step
  always_comb begin
    gather_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      gather_word = gather_word | grp_word[g];
    end
  end

  // command result and next list state
  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    res_data   = '0;
    res_ok     = 1'b1;
    res_pos    = cursor_r;
    case (cmd_r)
      CMD_CLEAR: begin
        count_nxt  = '0;
        cursor_nxt = '0;
        res_pos    = '0;
      end
      CMD_INSERT: begin
        if (full) begin
          res_ok = 1'b0;
        end else begin
          count_nxt = count_r + 1'b1;
          res_pos   = at_w;
        end
      end
      CMD_APPEND: begin
        if (full) begin
          res_ok = 1'b0;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (on_elem) begin
          count_nxt = count_r - 1'b1;
          res_data  = gather_word;
        end else begin
          res_ok = 1'b0;
        end
      end
      CMD_START: begin
        cursor_nxt = '0;
        res_pos    = '0;
      end
      CMD_END: begin
        cursor_nxt = count_r;
        res_pos    = count_r;
      end
      CMD_PREV: begin
        if (cursor_r != '0) begin
          cursor_nxt = cursor_r - 1'b1;
          res_pos    = cursor_r - 1'b1;
        end
      end
      CMD_NEXT: begin
        if (on_elem) begin
          cursor_nxt = cursor_r + 1'b1;
          res_pos    = cursor_r + 1'b1;
        end
      end
      CMD_MOVE: begin
        if (tgt_ext <= DEPTH_T) begin
          cursor_nxt = tgt_ext[CW-1:0];
          res_pos    = tgt_ext[CW-1:0];
        end
      end
      CMD_READ: begin
        if (on_elem) begin
          res_data = gather_word;
        end else begin
          res_ok = 1'b0;
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign pos_ext = TW'(res_pos);
  assign len_ext = TW'(count_nxt);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_cmd == CMD_ERASE) || (in_cmd == CMD_READ)) begin
            state_nxt = S_GATHER;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_GATHER: state_nxt = S_EXEC;
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= count_nxt;
        cursor_r    <= cursor_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      val_r <= in_item_value;
      tgt_r <= in_target_pos;
    end
    if (fire) begin
      out_data_r <= res_data;
      out_ok_r   <= res_ok;
      out_pos_r  <= pos_ext[9:0];
      out_len_r  <= len_ext[9:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_ok       = out_ok_r;
  assign out_position = out_pos_r;
  assign out_length   = out_len_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("element count beyond capacity");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= DEPTH_C)
    else $error("cursor beyond capacity");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (state_r == S_IDLE))
    else $error("executed command left no result");

  a_read_gather: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ((in_cmd == CMD_READ) || (in_cmd == CMD_ERASE)) |=> state_r == S_GATHER)
    else $error("cursor read skipped the gather step");
`endif

endmodule
`default_nettype wire

// ----- src/cale_cell.sv -----
`default_nettype none
module cale_cell
  import cale_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire word_t     left_word,
  input  wire word_t     right_word,
  input  wire word_t     load_word,
  output word_t          word,
  output word_t          tap
);

  word_t word_r;

  // one list entry; shifts with its neighbours
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word_r <= load_word;
    end else if (ctl.up) begin
      word_r <= left_word;
    end else if (ctl.dn) begin
      word_r <= right_word;
    end
  end

  assign word = word_r;
  // contributes to the cursor read only when selected
  assign tap  = ctl.sel ? word_r : '0;

endmodule
`default_nettype wire

// ----- src/cale_group.sv -----
`default_nettype none
module cale_group
  import cale_pkg::*;
#(
  parameter int GROUP = 32
) (
  input  wire logic              clk,
  input  wire word_t [GROUP-1:0] taps,
  output word_t                  grp_r
);

  word_t grp_nxt;

  // at most one tap is non-zero, so an OR picks it
  always_comb begin
    grp_nxt = '0;
    for (int k = 0; k < GROUP; k++) begin
      grp_nxt = grp_nxt | taps[k];
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

endmodule
`default_nettype wire
